>>> src/tce_pkg.sv
// Package for the telemetry event correlator.
// Holds shared constants, register indexes and the controller/datapath link types.
// No dependencies.
package tce_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int TIME_BITS_DEF = 48;

	localparam int SEQ_W     = 32;
	localparam int CAP_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SKEW        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXACT_ONLY      = 2'd2;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
	localparam int               MAX_SKEW_RESET = 1000000;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_MATCH = 1'b1;

	typedef struct packed {
		logic ready_in;
		logic push;
		logic scan;
		logic load_out;
	} tce_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic opcode;
		logic scan_done;
		logic out_busy;
	} tce_status_t;

endpackage

>>> src/tce_in_if.sv
// Request channel of the telemetry event correlator.
// Depends on tce_pkg for the sequence width.
interface tce_in_if import tce_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [SEQ_W-1:0]            sequence_req;
	logic [TIME_BITS-1:0]        sample_time;
	logic signed [TIME_BITS-1:0] sample_delta;
	logic [TIME_BITS-1:0]        window_start;
	logic [TIME_BITS-1:0]        window_end;
	logic                        launch_phase;
	logic                        driver_valid;
	logic [TIME_BITS-1:0]        gpu_launch_time;
	logic [TIME_BITS-1:0]        host_launch_time;
	logic [TIME_BITS-1:0]        gpu_done_time;
	logic [TIME_BITS-1:0]        host_done_time;

	modport source (output valid, opcode, sequence_req, sample_time, sample_delta,
		window_start, window_end, launch_phase, driver_valid, gpu_launch_time,
		host_launch_time, gpu_done_time, host_done_time, input ready);
	modport sink (input valid, opcode, sequence_req, sample_time, sample_delta,
		window_start, window_end, launch_phase, driver_valid, gpu_launch_time,
		host_launch_time, gpu_done_time, host_done_time, output ready);
endinterface

>>> src/tce_out_if.sv
// Result channel of the telemetry event correlator.
// Depends on tce_pkg for the sequence width.
interface tce_out_if import tce_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int CNT_W     = 7
);
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic                 seq_hit;
	logic [SEQ_W-1:0]     match_sequence;
	logic [TIME_BITS-1:0] match_time;
	logic [TIME_BITS:0]   skew;
	logic [CNT_W-1:0]     held_count;

	modport source (output valid, found, seq_hit, match_sequence, match_time, skew,
		held_count, input ready);
	modport sink (input valid, found, seq_hit, match_sequence, match_time, skew,
		held_count, output ready);
endinterface

>>> src/tce_cfg_if.sv
// Configuration write channel of the telemetry event correlator.
// Depends on tce_pkg for the index width.
interface tce_cfg_if import tce_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIME_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/tce_ctrl.sv
// Controller state machine of the telemetry event correlator.
// Depends on tce_pkg for the command and status types.
module tce_ctrl import tce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tce_status_t sts,
	output tce_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PUSH   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.ready_in = 1'b0;
		cmd.push     = 1'b0;
		cmd.scan     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready_in = 1'b1;
				if (sts.in_valid) begin
					state_d = (sts.opcode == OP_PUSH) ? S_PUSH : S_SCAN;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_RESULT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/tce_datapath.sv
// Datapath of the telemetry event correlator: sample ring memory, scan pipeline,
// configuration registers and result register. Depends on tce_pkg and the channel interfaces.
module tce_datapath import tce_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	tce_in_if.sink      in_req,
	tce_out_if.source   out_rsp,
	tce_cfg_if.sink     cfg,
	input  tce_cmd_t    cmd,
	output tce_status_t sts
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = AW + 1;
	localparam int TB    = TIME_BITS;
	localparam int STW   = TB + 2;
	localparam int ENT_W = SEQ_W + TB + STW + TB;

	// Ring entry layout: {sequence, time, start, end}.
	localparam int END_LO  = 0;
	localparam int ST_LO   = TB;
	localparam int TIME_LO = TB + STW;
	localparam int SEQ_LO  = TB + STW + TB;

	logic [ENT_W-1:0] mem [DEPTH];

	logic [CAP_W-1:0] cap_q;
	logic [TB-1:0]    max_skew_q;
	logic             exact_only_q;

	logic [AW-1:0]    oldest_q;
	logic [CNT_W-1:0] count_q;

	logic             opcode_q;
	logic [SEQ_W-1:0] seq_q;
	logic [TB-1:0]    time_q;
	logic [STW-1:0]   start_q;
	logic [TB-1:0]    end_q;
	logic [TB-1:0]    ref_q;

	logic [CNT_W-1:0] iss_k_q;
	logic [AW-1:0]    rd_ptr_q;
	logic             v_s1;
	logic [ENT_W-1:0] rd_s1;
	logic             v_s2;
	logic             seq_eq_s2;
	logic [SEQ_W-1:0] seq_s2;
	logic [TB-1:0]    time_s2;
	logic [TB-1:0]    dist_s2;
	logic [TB-1:0]    absd_s2;

	logic             hit_q;
	logic [SEQ_W-1:0] hit_seq_q;
	logic [TB-1:0]    hit_time_q;
	logic [TB-1:0]    hit_skew_q;
	logic             best_v_q;
	logic [SEQ_W-1:0] best_seq_q;
	logic [TB-1:0]    best_time_q;
	logic [TB-1:0]    best_d_q;

	logic             out_valid_q;

	logic capture;
	logic issue;
	assign capture = in_req.valid & cmd.ready_in;
	assign issue   = cmd.scan & (iss_k_q < count_q);

	assign in_req.ready  = cmd.ready_in;
	assign cfg.ready     = 1'b1;
	assign sts.in_valid  = in_req.valid;
	assign sts.opcode    = in_req.opcode;
	assign sts.scan_done = ~issue & ~v_s1 & ~v_s2;
	assign sts.out_busy  = out_valid_q & ~out_rsp.ready;
	assign out_rsp.valid = out_valid_q;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
		logic [SW-1:0] y;
		y = (x >= SW'(DEPTH)) ? x - SW'(DEPTH) : x;
		return y[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Reference time and sample window of the incoming request.
	logic [TB-1:0]  ref_in;
	logic [TB-1:0]  launch_ref;
	logic [TB-1:0]  delta_pos;
	logic [STW-1:0] start_in;
	always_comb begin
		launch_ref = (in_req.driver_valid && in_req.gpu_launch_time != '0) ?
			in_req.gpu_launch_time : in_req.host_launch_time;
		if (in_req.launch_phase) begin
			ref_in = launch_ref;
		end else if (in_req.driver_valid && in_req.gpu_done_time != '0) begin
			ref_in = in_req.gpu_done_time;
		end else if (in_req.host_done_time != '0) begin
			ref_in = in_req.host_done_time;
		end else begin
			ref_in = launch_ref;
		end
		delta_pos = in_req.sample_delta[TB-1] ? '0 : in_req.sample_delta;
		if (in_req.window_start != '0) begin
			start_in = {2'b00, in_req.window_start};
		end else begin
			start_in = {2'b00, in_req.sample_time} - {2'b00, delta_pos};
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			opcode_q <= in_req.opcode;
			seq_q    <= in_req.sequence_req;
			time_q   <= in_req.sample_time;
			start_q  <= start_in;
			end_q    <= (in_req.window_end != '0) ? in_req.window_end : in_req.sample_time;
			ref_q    <= ref_in;
		end
	end

	// Push bookkeeping: make room if full, append, then evict down to the capacity.
	logic [SW-1:0] cap_eff;
	logic [AW-1:0] o0;
	logic [SW-1:0] c0;
	logic [SW-1:0] c1;
	logic [SW-1:0] evict;
	logic [SW-1:0] c_new;
	logic [AW-1:0] wr_addr;
	always_comb begin
		cap_eff = (32'(cap_q) > 32'(DEPTH)) ? SW'(DEPTH) : SW'(cap_q);
		if (SW'(count_q) >= SW'(DEPTH)) begin
			o0 = inc_ptr(oldest_q);
			c0 = SW'(DEPTH - 1);
		end else begin
			o0 = oldest_q;
			c0 = SW'(count_q);
		end
		wr_addr = wrap(SW'(o0) + c0);
		c1      = c0 + 1'b1;
		if (c1 > cap_eff) begin
			evict = c1 - cap_eff;
			c_new = cap_eff;
		end else begin
			evict = '0;
			c_new = c1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= {seq_q, time_q, start_q, end_q};
		end
		rd_s1 <= mem[rd_ptr_q];
	end

	// Per-entry distance and exact-match test on the registered read data.
	logic [SEQ_W-1:0] e_seq;
	logic [TB-1:0]    e_time;
	logic [STW-1:0]   e_start;
	logic [TB-1:0]    e_end;
	logic [STW-1:0]   ref_ext;
	logic [STW-1:0]   st_diff;
	logic [TB-1:0]    dist_c;
	logic [TB-1:0]    absd_c;
	always_comb begin
		e_seq   = rd_s1[SEQ_LO +: SEQ_W];
		e_time  = rd_s1[TIME_LO +: TB];
		e_start = rd_s1[ST_LO +: STW];
		e_end   = rd_s1[END_LO +: TB];
		ref_ext = {2'b00, ref_q};
		st_diff = e_start - ref_ext;
		if ($signed(ref_ext) < $signed(e_start)) begin
			dist_c = st_diff[TB-1:0];
		end else if (ref_q > e_end) begin
			dist_c = ref_q - e_end;
		end else begin
			dist_c = '0;
		end
		absd_c = (e_time >= ref_q) ? e_time - ref_q : ref_q - e_time;
	end

	always_ff @(posedge clk) begin
		seq_eq_s2 <= (e_seq == seq_q);
		seq_s2    <= e_seq;
		time_s2   <= e_time;
		dist_s2   <= dist_c;
		absd_s2   <= absd_c;
		if (v_s2 && seq_q != '0 && seq_eq_s2 && !hit_q) begin
			hit_seq_q  <= seq_s2;
			hit_time_q <= time_s2;
			hit_skew_q <= absd_s2;
		end
		if (v_s2 && (!best_v_q || dist_s2 < best_d_q)) begin
			best_seq_q  <= seq_s2;
			best_time_q <= time_s2;
			best_d_q    <= dist_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAPACITY_RESET;
			max_skew_q   <= TB'(MAX_SKEW_RESET);
			exact_only_q <= 1'b0;
			oldest_q     <= '0;
			count_q      <= '0;
			iss_k_q      <= '0;
			rd_ptr_q     <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			hit_q        <= 1'b0;
			best_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_SAMPLE_CAPACITY: cap_q        <= cfg.data[CAP_W-1:0];
					REG_MAX_SKEW:        max_skew_q   <= cfg.data;
					REG_EXACT_ONLY:      exact_only_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (cmd.push) begin
				oldest_q <= wrap(SW'(o0) + evict);
				count_q  <= CNT_W'(c_new);
			end
			if (capture) begin
				iss_k_q  <= '0;
				rd_ptr_q <= oldest_q;
				hit_q    <= 1'b0;
				best_v_q <= 1'b0;
			end else if (issue) begin
				iss_k_q  <= iss_k_q + 1'b1;
				rd_ptr_q <= inc_ptr(rd_ptr_q);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2 && seq_q != '0 && seq_eq_s2) begin
				hit_q <= 1'b1;
			end
			if (v_s2) begin
				best_v_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rsp.found          <= 1'b0;
			out_rsp.seq_hit        <= 1'b0;
			out_rsp.match_sequence <= '0;
			out_rsp.match_time     <= '0;
			out_rsp.skew           <= '0;
			out_rsp.held_count     <= count_q;
			if (opcode_q == OP_MATCH) begin
				if (hit_q) begin
					out_rsp.found          <= 1'b1;
					out_rsp.seq_hit        <= 1'b1;
					out_rsp.match_sequence <= hit_seq_q;
					out_rsp.match_time     <= hit_time_q;
					out_rsp.skew           <= {1'b0, hit_skew_q};
				end else if (!exact_only_q && best_v_q && best_d_q <= max_skew_q) begin
					out_rsp.found          <= 1'b1;
					out_rsp.match_sequence <= best_seq_q;
					out_rsp.match_time     <= best_time_q;
					out_rsp.skew           <= {1'b0, best_d_q};
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("sample count exceeds ring depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(oldest_q) < 32'(DEPTH))
		else $error("oldest pointer outside ring");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("scan stage two valid without stage one");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iss_k_q <= count_q)
		else $error("scan index ran past the held count");

endmodule

>>> src/telemetry_event_correlator.sv
// Telemetry event correlator. A push request stores one sample in a ring of DEPTH entries. A
// match request scans the held samples oldest first, one ring memory read per cycle, through
// the single read port of the ring. One request is worked at a time; the result register lets
// the next request be accepted while a result waits.
module telemetry_event_correlator import tce_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tce_in_if.sink    in_req,
	tce_out_if.source out_rsp,
	tce_cfg_if.sink   cfg
);

	tce_cmd_t    cmd;
	tce_status_t sts;

	tce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tce_datapath #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS),
		.CNT_W     ($clog2(DEPTH + 1))
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_req  (in_req),
		.out_rsp (out_rsp),
		.cfg     (cfg),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

>>> tb/telemetry_event_correlator_tb.sv
`timescale 1ns / 1ps
// Testbench for the telemetry event correlator: drives pushes and matches, predicts each
// result with its own copy of the sample ring, and checks results in order.
// Depends on tce_pkg, tce_in_if, tce_out_if, tce_cfg_if and the correlator itself.

module telemetry_event_correlator_tb;
	import tce_pkg::*;

	localparam int TB = 48;
	localparam int RING = 64;

	typedef struct packed {
		logic        opcode;
		logic [31:0] seq;
		logic [TB-1:0] t;
		logic signed [TB-1:0] delta;
		logic [TB-1:0] ws;
		logic [TB-1:0] we;
		logic        launch;
		logic        dv;
		logic [TB-1:0] gl;
		logic [TB-1:0] hl;
		logic [TB-1:0] gd;
		logic [TB-1:0] hd;
	} request_t;

	typedef struct packed {
		logic        found;
		logic        exact;
		logic [31:0] seq;
		logic [TB-1:0] t;
		logic [TB:0] skew;
		logic [6:0]  held;
	} outcome_t;

	// Predicts correlator outcomes and holds those not yet seen on the result channel.
	class correlation_board;
		logic [31:0] seq_mem[RING];
		logic [TB-1:0] time_mem[RING];
		logic signed [49:0] start_mem[RING];
		logic [TB-1:0] end_mem[RING];
		int oldest, count;
		int capacity;
		logic [TB-1:0] skew_limit;
		bit exact_mode;
		outcome_t pending[$];
		int errors;

		function new();
			oldest = 0; count = 0; capacity = 64; skew_limit = 1000000; exact_mode = 0;
			errors = 0;
		endfunction

		function int slot(int k);
			return (oldest + k) % RING;
		endfunction

		function void note_request(request_t r);
			outcome_t o;
			logic [TB-1:0] rf, lref;
			logic signed [49:0] rs, dpos;
			logic [49:0] gap, best_d;
			int best, s, cap;
			o = '0;
			if (r.opcode == OP_PUSH) begin
				cap = capacity > RING ? RING : capacity;
				if (count >= RING) begin
					oldest = slot(1); count = RING - 1;
				end
				s = slot(count);
				dpos = r.delta > 0 ? 50'(r.delta) : 50'sd0;
				seq_mem[s] = r.seq;
				time_mem[s] = r.t;
				start_mem[s] = r.ws != 0 ? $signed({2'b00, r.ws}) : $signed({2'b00, r.t}) - dpos;
				end_mem[s] = r.we != 0 ? r.we : r.t;
				count++;
				while (count > cap) begin
					oldest = slot(1); count--;
				end
			end else begin
				lref = (r.dv && r.gl != 0) ? r.gl : r.hl;
				if (r.launch) rf = lref;
				else if (r.dv && r.gd != 0) rf = r.gd;
				else if (r.hd != 0) rf = r.hd;
				else rf = lref;
				if (r.seq != 0)
					for (int k = 0; k < count; k++) begin
						s = slot(k);
						if (seq_mem[s] == r.seq) begin
							o.found = 1; o.exact = 1; o.seq = seq_mem[s]; o.t = time_mem[s];
							o.skew = time_mem[s] >= rf ? time_mem[s] - rf : rf - time_mem[s];
							break;
						end
					end
				if (!o.found && !exact_mode && count != 0) begin
					best = 0; best_d = 0;
					rs = $signed({2'b00, rf});
					for (int k = 0; k < count; k++) begin
						s = slot(k);
						if (rs < start_mem[s]) gap = start_mem[s] - rs;
						else if (rf > end_mem[s]) gap = rf - end_mem[s];
						else gap = 0;
						if (k == 0 || gap < best_d) begin
							best = s; best_d = gap;
						end
					end
					if (best_d <= skew_limit) begin
						o.found = 1; o.seq = seq_mem[best]; o.t = time_mem[best];
						o.skew = best_d[TB:0];
					end
				end
			end
			o.held = 7'(count);
			pending.insert(pending.size(), o);
		endfunction

		function void check_result(outcome_t a);
			outcome_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = pending[0];
			pending.delete(0);
			if (a.found !== e.found) report("found", e.found, a.found);
			if (a.exact !== e.exact) report("seq_hit", e.exact, a.exact);
			if (a.seq !== e.seq) report("match_sequence", e.seq, a.seq);
			if (a.t !== e.t) report("match_time", e.t, a.t);
			if (a.skew !== e.skew) report("skew", e.skew, a.skew);
			if (a.held !== e.held) report("held_count", e.held, a.held);
		endfunction

		function void report(string f, logic [63:0] e, logic [63:0] a);
			$display("%0t: %s expected %0h got %0h", $time, f, e, a);
			errors++;
		endfunction
	endclass

	logic clk, arst_n;
	tce_in_if in_req();
	tce_out_if out_rsp();
	tce_cfg_if cfg();

	telemetry_event_correlator uut (.clk(clk), .arst_n(arst_n), .in_req(in_req.sink),
		.out_rsp(out_rsp.source), .cfg(cfg.sink));

	correlation_board board;
	longint cycles;
	int hold_off;
	bit long_stall_req;
	logic [TB-1:0] recent_time;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("telemetry_event_correlator: mismatch");
			$finish;
		end
	end

	// Result side: a stall pattern of its own plus one long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_rsp.valid && out_rsp.ready)
				board.check_result({out_rsp.found, out_rsp.seq_hit, out_rsp.match_sequence,
					out_rsp.match_time, out_rsp.skew, out_rsp.held_count});
			if (long_stall_req && hold_off == 0) begin
				hold_off <= 600;
				long_stall_req <= 0;
				out_rsp.ready <= 0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_rsp.ready <= (hold_off == 1);
			end else
				out_rsp.ready <= (cycles % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send(request_t r);
		in_req.valid <= 1;
		{in_req.opcode, in_req.sequence_req, in_req.sample_time, in_req.sample_delta,
			in_req.window_start, in_req.window_end, in_req.launch_phase, in_req.driver_valid,
			in_req.gpu_launch_time, in_req.host_launch_time, in_req.gpu_done_time,
			in_req.host_done_time} <= r;
		do @(posedge clk); while (!in_req.ready);
		board.note_request(r);
	endtask

	task automatic pause(int n);
		in_req.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Leaves the channel idle after each write so that back-to-back writes never collide.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TB-1:0] val);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		if (idx == REG_SAMPLE_CAPACITY) board.capacity = val[6:0];
		else if (idx == REG_MAX_SKEW) board.skew_limit = val;
		else board.exact_mode = val[0];
		@(posedge clk);
	endtask

	task automatic drain();
		in_req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [TB-1:0] rand_time();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom} & {TB{1'b1}};
			1: return 0;
			2: return {TB{1'b1}} - $urandom_range(0, 3);
			default: return recent_time + $urandom_range(0, 4000) - 2000;
		endcase
	endfunction

	function automatic request_t make_push();
		request_t r;
		r = '0;
		r.opcode = OP_PUSH;
		r.seq = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40);
		recent_time = recent_time + $urandom_range(0, 3000);
		r.t = $urandom_range(0, 9) == 0 ? rand_time() : recent_time;
		case ($urandom_range(0, 3))
			0: r.delta = {$urandom, $urandom};
			1: r.delta = -$signed(48'($urandom_range(0, 5000)));
			default: r.delta = $urandom_range(0, 5000);
		endcase
		r.ws = $urandom_range(0, 2) == 0 ? rand_time() : 0;
		r.we = $urandom_range(0, 2) == 0 ? rand_time() : 0;
		r.launch = $urandom; r.dv = $urandom;
		r.gl = {$urandom, $urandom}; r.hl = {$urandom, $urandom};
		r.gd = {$urandom, $urandom}; r.hd = {$urandom, $urandom};
		return r;
	endfunction

	function automatic request_t make_match();
		request_t r;
		r = '0;
		r.opcode = OP_MATCH;
		case ($urandom_range(0, 3))
			0: r.seq = 0;
			1: r.seq = $urandom;
			default: r.seq = $urandom_range(0, 40);
		endcase
		r.t = {$urandom, $urandom}; r.delta = {$urandom, $urandom};
		r.ws = {$urandom, $urandom}; r.we = {$urandom, $urandom};
		r.launch = $urandom; r.dv = $urandom;
		r.gl = $urandom_range(0, 1) ? rand_time() : 0;
		r.hl = rand_time();
		r.gd = $urandom_range(0, 1) ? rand_time() : 0;
		r.hd = $urandom_range(0, 1) ? rand_time() : 0;
		return r;
	endfunction

	initial begin
		request_t r;
		int sent;
		board = new();
		cycles = 0; hold_off = 0; long_stall_req = 0;
		recent_time = 48'h1000_0000;
		arst_n = 0;
		in_req.valid = 0; in_req.opcode = 0; in_req.sequence_req = 0; in_req.sample_time = 0;
		in_req.sample_delta = 0; in_req.window_start = 0; in_req.window_end = 0;
		in_req.launch_phase = 0; in_req.driver_valid = 0; in_req.gpu_launch_time = 0;
		in_req.host_launch_time = 0; in_req.gpu_done_time = 0; in_req.host_done_time = 0;
		out_rsp.ready = 0;
		cfg.valid = 0; cfg.index = REG_SAMPLE_CAPACITY; cfg.data = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty buffer, extremes, exact hint, negative delta, inverted window.
		r = make_match(); r.seq = 5; send(r);
		r = make_push(); r.seq = 32'hFFFF_FFFF; r.t = {TB{1'b1}}; r.ws = 0; r.we = 0;
		r.delta = {1'b0, {TB-1{1'b1}}}; send(r);
		r = make_push(); r.seq = 7; r.t = 1; r.ws = 0; r.we = 0;
		r.delta = {1'b1, {TB-1{1'b0}}}; send(r);
		r = make_push(); r.seq = 0; r.t = 100; r.ws = 500; r.we = 50; send(r);
		r = make_match(); r.seq = 32'hFFFF_FFFF; send(r);
		r = make_match(); r.seq = 0; r.launch = 1; r.dv = 1; r.gl = 0; r.hl = 60; send(r);
		r = make_match(); r.seq = 9; r.launch = 0; r.dv = 0; r.gd = 5; r.hd = 0;
		r.hl = 300; send(r);
		r = make_match(); r.seq = 0; r.launch = 0; r.dv = 1; r.gd = {TB{1'b1}}; send(r);
		drain();
		write_reg(REG_MAX_SKEW, {TB{1'b1}});
		r = make_match(); r.seq = 0; r.launch = 1; r.dv = 0; r.hl = 0; send(r);
		drain();
		write_reg(REG_EXACT_ONLY, 1);
		r = make_match(); r.seq = 3; send(r);
		r = make_match(); r.seq = 7; send(r);
		drain();
		write_reg(REG_SAMPLE_CAPACITY, 0);
		r = make_push(); send(r);
		drain();
		write_reg(REG_SAMPLE_CAPACITY, 127);
		write_reg(REG_EXACT_ONLY, 0);
		write_reg(REG_MAX_SKEW, 0);
		r = make_match(); send(r);
		drain();

		sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_SAMPLE_CAPACITY, 64); write_reg(REG_MAX_SKEW, 1000000); end
				1: begin write_reg(REG_SAMPLE_CAPACITY, 3); write_reg(REG_MAX_SKEW, 500); end
				2: begin write_reg(REG_SAMPLE_CAPACITY, 1); write_reg(REG_EXACT_ONLY, 1); end
				3: begin write_reg(REG_SAMPLE_CAPACITY, 100); write_reg(REG_EXACT_ONLY, 0);
					write_reg(REG_MAX_SKEW, {TB{1'b1}}); end
				4: begin write_reg(REG_SAMPLE_CAPACITY, 16); write_reg(REG_MAX_SKEW, 2000); end
				default: begin write_reg(REG_SAMPLE_CAPACITY, 64); write_reg(REG_MAX_SKEW, 0); end
			endcase
			if (phase == 3) long_stall_req = 1;
			for (int n = 0; n < 175; ) begin
				int burst;
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < 175; b++, n++) begin
					r = ($urandom_range(0, 9) < 5) ? make_push() : make_match();
					send(r);
					sent++;
				end
				if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("telemetry_event_correlator: match");
		else
			$display("telemetry_event_correlator: mismatch");
		$finish;
	end
endmodule
